FILE: rtl/pspm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pspm_pkg
// Shared constants, weight tables and helper functions of the phase-shift
// phase/modulation core.
// ----------------------------------------------------------------------------
package pspm_pkg;

    localparam int SampleBitsDef   = 16;
    localparam int CordicStagesDef = 16;

    localparam int PHASE_W = 16;
    localparam int MOD_W   = 16;

    localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;
    localparam logic signed [15:0] PI_Q13      = 16'sd25736;
    localparam int                 HALF_PI_Q16 = 102944;

    // register addresses (word index)
    typedef enum logic [1:0] {
        REG_STEP_MODE = 2'd0,
        REG_ROTATE    = 2'd1,
        REG_REVERSE   = 2'd2,
        REG_NONE      = 2'd3
    } reg_idx_t;

    // step modes
    localparam logic [1:0] MODE_4  = 2'd0;
    localparam logic [1:0] MODE_6  = 2'd1;
    localparam logic [1:0] MODE_8  = 2'd2;
    localparam logic [1:0] MODE_16 = 2'd3;

    function automatic logic [4:0] step_count(input logic [1:0] mode);
        logic [4:0] c;
        begin
            case (mode)
                MODE_4:  c = 5'd4;
                MODE_6:  c = 5'd6;
                MODE_8:  c = 5'd8;
                default: c = 5'd16;
            endcase
            return c;
        end
    endfunction

    // sine weights of each decode position (negated in the 8-step mode), Q14, Q15 in the 16-step mode
    function automatic logic signed [16:0] num_weight(input logic [1:0] mode,
                                                      input logic [3:0] k);
        logic signed [16:0] w;
        begin
            w = '0;
            case (mode)
                MODE_4: begin
                    case (k)
                        4'd1: w = 17'sd16384;
                        4'd3: w = -17'sd16384;
                        default: w = '0;
                    endcase
                end
                MODE_6: begin
                    case (k)
                        4'd1, 4'd2: w = 17'sd14189;
                        4'd4, 4'd5: w = -17'sd14189;
                        default: w = '0;
                    endcase
                end
                MODE_8: begin
                    case (k)
                        4'd1, 4'd3: w = -17'sd11585;
                        4'd2: w = -17'sd16384;
                        4'd5, 4'd7: w = 17'sd11585;
                        4'd6: w = 17'sd16384;
                        default: w = '0;
                    endcase
                end
                default: begin
                    case (k)
                        4'd1, 4'd7: w = 17'sd12540;
                        4'd2, 4'd6: w = 17'sd23170;
                        4'd3, 4'd5: w = 17'sd30274;
                        4'd4: w = 17'sd32768;
                        4'd9, 4'd15: w = -17'sd12540;
                        4'd10, 4'd14: w = -17'sd23170;
                        4'd11, 4'd13: w = -17'sd30274;
                        4'd12: w = -17'sd32768;
                        default: w = '0;
                    endcase
                end
            endcase
            return w;
        end
    endfunction

    function automatic logic signed [16:0] den_weight(input logic [1:0] mode,
                                                      input logic [3:0] k);
        logic signed [16:0] w;
        begin
            w = '0;
            case (mode)
                MODE_4: begin
                    case (k)
                        4'd0: w = -17'sd16384;
                        4'd2: w = 17'sd16384;
                        default: w = '0;
                    endcase
                end
                MODE_6: begin
                    case (k)
                        4'd0, 4'd1, 4'd5: w = -17'sd8192;
                        4'd2, 4'd3, 4'd4: w = 17'sd8192;
                        default: w = '0;
                    endcase
                end
                MODE_8: begin
                    case (k)
                        4'd0: w = 17'sd16384;
                        4'd1, 4'd7: w = 17'sd11585;
                        4'd3, 4'd5: w = -17'sd11585;
                        4'd4: w = -17'sd16384;
                        default: w = '0;
                    endcase
                end
                default: begin
                    case (k)
                        4'd0: w = -17'sd32768;
                        4'd1, 4'd15: w = -17'sd30274;
                        4'd2, 4'd14: w = -17'sd23170;
                        4'd3, 4'd13: w = -17'sd12540;
                        4'd5, 4'd11: w = 17'sd12540;
                        4'd6, 4'd10: w = 17'sd23170;
                        4'd7, 4'd9: w = 17'sd30274;
                        4'd8: w = 17'sd32768;
                        default: w = '0;
                    endcase
                end
            endcase
            return w;
        end
    endfunction

    // arctangent table, Q16
    function automatic logic [15:0] atan_q16(input logic [4:0] i);
        logic [15:0] a;
        begin
            case (i)
                5'd0:  a = 16'd51472;
                5'd1:  a = 16'd30386;
                5'd2:  a = 16'd16055;
                5'd3:  a = 16'd8150;
                5'd4:  a = 16'd4091;
                5'd5:  a = 16'd2047;
                5'd6:  a = 16'd1024;
                5'd7:  a = 16'd512;
                5'd8:  a = 16'd256;
                5'd9:  a = 16'd128;
                5'd10: a = 16'd64;
                5'd11: a = 16'd32;
                5'd12: a = 16'd16;
                5'd13: a = 16'd8;
                5'd14: a = 16'd4;
                5'd15: a = 16'd2;
                5'd16: a = 16'd1;
                default: a = 16'd0;
            endcase
            return a;
        end
    endfunction

    // job handed from accumulator to the cell chain
    typedef struct packed {
        logic       valid;
        logic       err;
        logic [1:0] mode;
    } pspm_job_t;

endpackage

FILE: rtl/pspm_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pspm_accum
// Maps each sample to its decode position and accumulates the weighted
// numerator and denominator sums of one pixel.
// ----------------------------------------------------------------------------
module pspm_accum
    import pspm_pkg::*;
#(
    parameter int SAMPLE_BITS = SampleBitsDef,
    parameter int SUM_W       = SampleBitsDef + 24
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    clear,
    input  logic                    take,
    input  logic [15:0]             sample,
    input  logic [1:0]              step_mode,
    input  logic [4:0]              rotate_amount,
    input  logic                    reverse_order,
    output logic                    last,
    output logic                    err,
    output logic signed [SUM_W-1:0] num_total,
    output logic signed [SUM_W-1:0] den_total
);

    localparam int PW = SAMPLE_BITS + 18;

    logic [3:0]              idx_reg;
    logic signed [SUM_W-1:0] num_reg;
    logic signed [SUM_W-1:0] den_reg;

    logic [4:0] cnt;
    logic [4:0] rot;
    logic [4:0] j;
    logic [4:0] k;
    logic [4:0] i_ext;
    logic [SAMPLE_BITS-1:0]      s_bits;
    logic signed [SAMPLE_BITS:0] s_val;
    logic signed [16:0]          nw;
    logic signed [16:0]          dw;
    logic signed [PW-1:0]        num_prod;
    logic signed [PW-1:0]        den_prod;
    logic signed [SUM_W-1:0] num_add;
    logic signed [SUM_W-1:0] den_add;

    // decode position of this sample
    always_comb
    begin
        cnt   = step_count(step_mode);
        i_ext = {1'b0, idx_reg};
        rot   = (rotate_amount >= cnt) ? rotate_amount - cnt : rotate_amount;
        if (rot >= cnt)
        begin
            rot = rot - cnt;
        end
        j     = (i_ext >= rot) ? i_ext - rot : i_ext + cnt - rot;
        k     = reverse_order ? cnt - 5'd1 - j : j;
        last  = (i_ext + 5'd1 >= cnt);
        err   = rotate_amount > cnt;
    end

    // weighted sample, product kept at full width
    always_comb
    begin
        s_bits   = SAMPLE_BITS'(sample);
        s_val    = $signed({1'b0, s_bits});
        nw       = num_weight(step_mode, k[3:0]);
        dw       = den_weight(step_mode, k[3:0]);
        num_prod = PW'(nw) * PW'(s_val);
        den_prod = PW'(dw) * PW'(s_val);
        num_add  = SUM_W'(num_prod);
        den_add  = SUM_W'(den_prod);
    end

    assign num_total = num_reg + num_add;
    assign den_total = den_reg + den_add;

    // advance index and sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            num_reg <= '0;
            den_reg <= '0;
        end
        else if (clear)
        begin
            idx_reg <= '0;
            num_reg <= '0;
            den_reg <= '0;
        end
        else if (take)
        begin
            if (last)
            begin
                idx_reg <= '0;
                num_reg <= '0;
                den_reg <= '0;
            end
            else
            begin
                idx_reg <= idx_reg + 4'd1;
                num_reg <= num_total;
                den_reg <= den_total;
            end
        end
    end

endmodule

FILE: rtl/pspm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pspm_cell
// One cell of the decode chain: one CORDIC vectoring step on (x, y, z), skipped past CSTAGES, and
// one bit of the restoring square-root search for the modulation, skipped past MBITS.
// ----------------------------------------------------------------------------
module pspm_cell
    import pspm_pkg::*;
#(
    parameter int XW     = SampleBitsDef + 27,
    parameter int SQ_W   = 2 * (SampleBitsDef + 24),
    parameter int MBITS  = SampleBitsDef,
    parameter int CSTEP  = 0,
    parameter int MSTEP  = 0,
    parameter int CSTAGES = CordicStagesDef
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic signed [XW-1:0]  x_in,
    input  logic signed [XW-1:0]  y_in,
    input  logic signed [19:0]    z_in,
    input  logic [SQ_W:0]         rem_in,
    input  logic [MBITS-1:0]      m_in,
    input  logic [2*MBITS-1:0]    msq_in,
    input  logic [1:0]            mode_in,
    output logic                  out_valid,
    output logic signed [XW-1:0]  x_out,
    output logic signed [XW-1:0]  y_out,
    output logic signed [19:0]    z_out,
    output logic [SQ_W:0]         rem_out,
    output logic [MBITS-1:0]      m_out,
    output logic [2*MBITS-1:0]    msq_out,
    output logic [1:0]            mode_out
);

    localparam int MSQ_W = 2 * MBITS;
    localparam int TW    = SQ_W + 1;
    localparam int MB    = (MSTEP < MBITS) ? MBITS - 1 - MSTEP : 0;

    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [19:0]   ang;
    logic signed [XW-1:0] x_next;
    logic signed [XW-1:0] y_next;
    logic signed [19:0]   z_next;
    logic [MBITS-1:0]     m_next;
    logic [MSQ_W-1:0]     msq_next;
    logic [MBITS-1:0]     cand;
    logic [MSQ_W-1:0]     cand_sq;
    logic [TW-1:0]        trial;
    logic                 valid_reg;
    logic signed [XW-1:0] x_reg;
    logic signed [XW-1:0] y_reg;
    logic signed [19:0]   z_reg;
    logic [SQ_W:0]        rem_reg;
    logic [MBITS-1:0]     m_reg;
    logic [MSQ_W-1:0]     msq_reg;
    logic [1:0]           mode_reg;

    // vectoring step: arithmetic shift is a floor shift
    always_comb
    begin
        dx  = y_in >>> CSTEP;
        dy  = x_in >>> CSTEP;
        ang = $signed({4'd0, atan_q16(5'(CSTEP))});
        if (CSTEP >= CSTAGES)
        begin
            x_next = x_in;
            y_next = y_in;
            z_next = z_in;
        end
        else if (!y_in[XW-1])
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ang;
        end
        else
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ang;
        end
    end

    // trial bit of the modulation: keep it when c^2 * scale^2 <= n^2+d^2;
    // c^2 grows by shifts and adds, scale^2 is 2^28, 9*2^26, 2^30 or 2^34
    always_comb
    begin
        cand    = m_in;
        cand_sq = msq_in;
        if (MSTEP < MBITS)
        begin
            cand[MB] = 1'b1;
            cand_sq  = msq_in + (MSQ_W'(m_in) << (MB + 1)) + (MSQ_W'(1) << (2 * MB));
        end
        case (mode_in)
            MODE_4:  trial = TW'(cand_sq) << 28;
            MODE_6:  trial = (TW'(cand_sq) << 29) + (TW'(cand_sq) << 26);
            MODE_8:  trial = TW'(cand_sq) << 30;
            default: trial = TW'(cand_sq) << 34;
        endcase
        m_next   = m_in;
        msq_next = msq_in;
        if ((MSTEP < MBITS) && (trial <= rem_in))
        begin
            m_next   = cand;
            msq_next = cand_sq;
        end
    end

    // hand the word to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        rem_reg  <= rem_in;
        m_reg    <= m_next;
        msq_reg  <= msq_next;
        mode_reg <= mode_in;
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign rem_out   = rem_reg;
    assign m_out     = m_reg;
    assign msq_out   = msq_reg;
    assign mode_out  = mode_reg;

endmodule

FILE: rtl/phase_shift_phase_modulation_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phase_shift_phase_modulation_core
// N-step phase-shifting decoder: accumulates 4/6/8/16 samples per pixel and
// emits wrapped phase and modulation through a chain of decode cells.
// ----------------------------------------------------------------------------
// One sample word is taken per cycle while no pixel is in decode. After the
// last sample of a pixel the sums pass an entry stage and a squaring stage
// (partial products, then their sum) and enter a chain of identical cells,
// at most one CORDIC step and one modulation bit per cell, then the output
// register; the chain holds one pixel at a time and input stays stalled
// until the result word is taken. A write to any of the three configuration
// registers restarts the current pixel.
module phase_shift_phase_modulation_core
    import pspm_pkg::*;
#(
    parameter int SAMPLE_BITS   = SampleBitsDef,
    parameter int CORDIC_STAGES = CordicStagesDef
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        sample_valid,
    output logic        sample_ready,
    input  logic [15:0] sample,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [15:0] phase,
    output logic [15:0] modulation,
    output logic        config_error
);

    localparam int SUM_W  = SAMPLE_BITS + 24;
    localparam int XW     = SUM_W + 3;
    localparam int SQ_W   = 2 * SUM_W;
    localparam int NCELLS = (CORDIC_STAGES > SAMPLE_BITS) ? CORDIC_STAGES : SAMPLE_BITS;
    localparam int HALF   = (SUM_W + 1) / 2;
    localparam int HI     = SUM_W - HALF;

    logic [1:0] step_mode_reg;
    logic [4:0] rotate_reg;
    logic       reverse_reg;
    logic       busy_reg;
    logic       cfg_wr;
    reg_idx_t   widx;

    logic                    last;
    logic                    err;
    logic signed [SUM_W-1:0] num_total;
    logic signed [SUM_W-1:0] den_total;
    logic                    take;

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign widx   = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_mode_reg <= '0;
            rotate_reg    <= '0;
            reverse_reg   <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (widx)
                REG_STEP_MODE: step_mode_reg <= pwdata[1:0];
                REG_ROTATE:    rotate_reg    <= pwdata[4:0];
                REG_REVERSE:   reverse_reg   <= pwdata[0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx_t'(paddr[3:2]))
            REG_STEP_MODE: prdata = {30'd0, step_mode_reg};
            REG_ROTATE:    prdata = {27'd0, rotate_reg};
            REG_REVERSE:   prdata = {31'd0, reverse_reg};
            default:       prdata = '0;
        endcase
    end

    assign sample_ready = !busy_reg;
    assign take         = sample_valid && sample_ready;

    pspm_accum #(.SAMPLE_BITS(SAMPLE_BITS), .SUM_W(SUM_W)) u_accum (
        .clk           (clk),
        .rst_n         (rst_n),
        .clear         (cfg_wr && (widx != REG_NONE)),
        .take          (take),
        .sample        (sample),
        .step_mode     (step_mode_reg),
        .rotate_amount (rotate_reg),
        .reverse_order (reverse_reg),
        .last          (last),
        .err           (err),
        .num_total     (num_total),
        .den_total     (den_total)
    );

    // entry stage: quadrant turn, magnitudes
    pspm_job_t              job_reg;
    logic signed [XW-1:0]   x0_reg;
    logic signed [XW-1:0]   y0_reg;
    logic signed [19:0]     z0_reg;
    logic                   zero_reg;
    logic [SUM_W-1:0]       an_reg;
    logic [SUM_W-1:0]       ad_reg;
    logic [SQ_W:0]          sq_reg;
    logic                   pp_valid_reg;
    logic                   sq_valid_reg;
    logic [1:0]             mode1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_reg      <= '0;
            pp_valid_reg <= 1'b0;
            sq_valid_reg <= 1'b0;
        end
        else
        begin
            job_reg.valid <= take && last;
            pp_valid_reg  <= job_reg.valid;
            sq_valid_reg  <= pp_valid_reg;
            if (take && last)
            begin
                job_reg.err  <= err;
                job_reg.mode <= step_mode_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && last)
        begin
            zero_reg <= (num_total == '0) && (den_total == '0);
            an_reg   <= num_total[SUM_W-1] ? SUM_W'(-num_total) : SUM_W'(num_total);
            ad_reg   <= den_total[SUM_W-1] ? SUM_W'(-den_total) : SUM_W'(den_total);
            if (!den_total[SUM_W-1])
            begin
                x0_reg <= XW'(den_total);
                y0_reg <= XW'(num_total);
                z0_reg <= '0;
            end
            else if (!num_total[SUM_W-1])
            begin
                x0_reg <= XW'(num_total);
                y0_reg <= XW'(-den_total);
                z0_reg <= 20'(HALF_PI_Q16);
            end
            else
            begin
                x0_reg <= XW'(-num_total);
                y0_reg <= XW'(den_total);
                z0_reg <= -20'(HALF_PI_Q16);
            end
        end
    end

    // square sum: half-width partial products are registered, then their sum;
    // x/y/z and flags stay fixed while the pixel is in flight
    logic [HALF-1:0]      an_lo;
    logic [HI-1:0]        an_hi;
    logic [HALF-1:0]      ad_lo;
    logic [HI-1:0]        ad_hi;
    logic [2*HALF-1:0]    nll_reg;
    logic [HALF+HI-1:0]   nhl_reg;
    logic [2*HI-1:0]      nhh_reg;
    logic [2*HALF-1:0]    dll_reg;
    logic [HALF+HI-1:0]   dhl_reg;
    logic [2*HI-1:0]      dhh_reg;
    logic signed [XW-1:0] x1_reg;
    logic signed [XW-1:0] y1_reg;
    logic signed [19:0]   z1_reg;
    logic                 zero1_reg;
    logic                 err1_reg;

    assign an_lo = an_reg[HALF-1:0];
    assign an_hi = an_reg[SUM_W-1:HALF];
    assign ad_lo = ad_reg[HALF-1:0];
    assign ad_hi = ad_reg[SUM_W-1:HALF];

    always_ff @(posedge clk)
    begin
        nll_reg   <= (2*HALF)'(an_lo) * (2*HALF)'(an_lo);
        nhl_reg   <= (HALF+HI)'(an_hi) * (HALF+HI)'(an_lo);
        nhh_reg   <= (2*HI)'(an_hi) * (2*HI)'(an_hi);
        dll_reg   <= (2*HALF)'(ad_lo) * (2*HALF)'(ad_lo);
        dhl_reg   <= (HALF+HI)'(ad_hi) * (HALF+HI)'(ad_lo);
        dhh_reg   <= (2*HI)'(ad_hi) * (2*HI)'(ad_hi);
        sq_reg    <= ((SQ_W+1)'(nhh_reg) << (2*HALF)) + ((SQ_W+1)'(nhl_reg) << (HALF+1))
                   + (SQ_W+1)'(nll_reg)
                   + ((SQ_W+1)'(dhh_reg) << (2*HALF)) + ((SQ_W+1)'(dhl_reg) << (HALF+1))
                   + (SQ_W+1)'(dll_reg);
        x1_reg    <= x0_reg;
        y1_reg    <= y0_reg;
        z1_reg    <= z0_reg;
        zero1_reg <= zero_reg;
        err1_reg  <= job_reg.err;
        mode1_reg <= job_reg.mode;
    end

    // cell chain
    logic                 cv [0:NCELLS];
    logic signed [XW-1:0] cx [0:NCELLS];
    logic signed [XW-1:0] cy [0:NCELLS];
    logic signed [19:0]   cz [0:NCELLS];
    logic [SQ_W:0]        cr [0:NCELLS];
    logic [SAMPLE_BITS-1:0] cm [0:NCELLS];
    logic [2*SAMPLE_BITS-1:0] cq [0:NCELLS];
    logic [1:0]           cmd [0:NCELLS];

    assign cv[0]  = sq_valid_reg;
    assign cx[0]  = x1_reg;
    assign cy[0]  = y1_reg;
    assign cz[0]  = z1_reg;
    assign cr[0]  = sq_reg;
    assign cm[0]  = '0;
    assign cq[0]  = '0;
    assign cmd[0] = mode1_reg;

    // zero/err flags ride alongside the chain
    logic [NCELLS:0] zero_line_reg;
    logic [NCELLS:0] err_line_reg;

    always_ff @(posedge clk)
    begin
        zero_line_reg <= {zero_line_reg[NCELLS-1:0], zero1_reg};
        err_line_reg  <= {err_line_reg[NCELLS-1:0], err1_reg};
    end

    genvar g;
    generate
        for (g = 0; g < NCELLS; g++)
        begin : g_cell
            pspm_cell #(
                .XW      (XW),
                .SQ_W    (SQ_W),
                .MBITS   (SAMPLE_BITS),
                .CSTEP   (g),
                .MSTEP   (g),
                .CSTAGES (CORDIC_STAGES)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (cv[g]),
                .x_in      (cx[g]),
                .y_in      (cy[g]),
                .z_in      (cz[g]),
                .rem_in    (cr[g]),
                .m_in      (cm[g]),
                .msq_in    (cq[g]),
                .mode_in   (cmd[g]),
                .out_valid (cv[g+1]),
                .x_out     (cx[g+1]),
                .y_out     (cy[g+1]),
                .z_out     (cz[g+1]),
                .rem_out   (cr[g+1]),
                .m_out     (cm[g+1]),
                .msq_out   (cq[g+1]),
                .mode_out  (cmd[g+1])
            );
        end
    endgenerate

    // final rounding and output word
    logic signed [19:0] zr;
    logic signed [16:0] q;
    logic signed [15:0] ph;
    logic               zf;
    logic               ef;

    always_comb
    begin
        zf = zero_line_reg[NCELLS-1];
        ef = err_line_reg[NCELLS-1];
        zr = (cz[NCELLS] + 20'sd4) >>> 3;
        q  = 17'(zr);
        if (q > 17'(PI_Q13))
        begin
            q = 17'(PI_Q13);
        end
        else if (q < -17'(PI_Q13))
        begin
            q = -17'(PI_Q13);
        end
        if (ef)
        begin
            ph = '0;
        end
        else if (zf)
        begin
            ph = HALF_PI_Q13;
        end
        else
        begin
            ph = 16'(q);
        end
    end

    logic [15:0] phase_reg;
    logic [15:0] mod_reg;
    logic        err_reg;
    logic        out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cv[NCELLS])
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cv[NCELLS])
        begin
            phase_reg <= ph;
            mod_reg   <= ef ? 16'd0 : 16'(cm[NCELLS]);
            err_reg   <= ef;
        end
    end

    // one pixel in flight from last sample until its word is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (take && last)
        begin
            busy_reg <= 1'b1;
        end
        else if (out_valid_reg && result_ready)
        begin
            busy_reg <= 1'b0;
        end
    end

    assign result_valid = out_valid_reg;
    assign phase        = phase_reg;
    assign modulation   = mod_reg;
    assign config_error = err_reg;

    // a result only while a pixel is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy_reg)
        else $error("result without pixel in flight");

    // no sample taken while decoding
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !sample_ready)
        else $error("sample taken during decode");

    // error results carry zero phase and modulation
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && config_error) |-> (phase == 16'd0 && modulation == 16'd0))
        else $error("error result not cleared");

endmodule
